@@ design/sliding_window_sum_mean_root_top_macros.svh @@
// Assertion macros for the sliding window sum, mean and root block.
// Used by the top level only; relies on clk and arst_n being in scope there.
`ifndef SLIDING_WINDOW_SUM_MEAN_ROOT_TOP_MACROS_SVH
`define SLIDING_WINDOW_SUM_MEAN_ROOT_TOP_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising edge outside reset.
`define SWSMR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("swsmr: same-cycle check failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define SWSMR_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("swsmr: next-cycle check failed");
`else
`define SWSMR_ASSERT_IMP(label, ante, cons)
`define SWSMR_ASSERT_NXT(label, ante, cons)
`endif

`endif

@@ design/swsmr_pkg.sv @@
// Shared types, constants and helpers for the sliding window sum block.
// No dependencies; imported by every module of the block.
`default_nettype none

package swsmr_pkg;

	localparam int WINDOW_MAX  = 64;
	localparam int SAMPLE_BITS = 16;
	localparam int PTR_W       = $clog2(WINDOW_MAX);
	localparam int LEN_W       = 7;
	localparam int MODE_W      = 2;
	localparam int VALUE_W     = 22;
	localparam int SUM_W       = 23;
	localparam int FRAC_BITS   = 12;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 7;
	localparam int Q_DEPTH     = 2;
	localparam int Q_PTR_W     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

	// Iterative unit sizing: the radicand is the sum scaled by 2^FRAC_BITS.
	localparam int ROOT_IN_W   = VALUE_W + FRAC_BITS;
	localparam int DIV_STEPS   = VALUE_W;
	localparam int ROOT_STEPS  = ROOT_IN_W / 2;
	localparam int STEP_CNT_W  = $clog2(DIV_STEPS);
	localparam int REM_W       = ROOT_STEPS + 3;

	localparam logic [MODE_W-1:0] MODE_SUM  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MEAN = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ROOT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODE       = 2'd1;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          new_series;
	} item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] window_value;
		logic                      negative_root;
	} result_t;

	// One finished window sum on its way to the back end.
	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [LEN_W-1:0]        len;
		logic [MODE_W-1:0]       mode;
	} entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

	// Window length as used: zero counts as one, and it saturates at the delay line depth.
	function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] res;
		if (len == '0) begin
			res = LEN_W'(1);
		end else if (len > LEN_W'(WINDOW_MAX)) begin
			res = LEN_W'(WINDOW_MAX);
		end else begin
			res = len;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

@@ design/swsmr_front.sv @@
// Front end: holds the configuration, the delay line memory and the running sum.
// Depends on swsmr_pkg; feeds finished window sums to swsmr_queue.
`default_nettype none

module swsmr_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  swsmr_pkg::item_t                 item,
	input  logic                             cfg_valid,
	input  logic [swsmr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [swsmr_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                             q_push,
	output swsmr_pkg::entry_t                q_entry,
	input  swsmr_pkg::qstat_t                q_stat
);
	import swsmr_pkg::*;

	typedef enum logic {F_IDLE, F_UPDATE} fstate_t;

	fstate_t                        state_q;
	logic [LEN_W-1:0]               len_q;
	logic [MODE_W-1:0]              mode_q;
	logic signed [SUM_W-1:0]        sum_q;
	logic [LEN_W-1:0]               fill_q;
	logic [PTR_W-1:0]               wp_q;
	item_t                          item_s1;
	logic signed [SAMPLE_BITS-1:0]  old_s1;
	logic signed [SAMPLE_BITS-1:0]  mem [WINDOW_MAX];

	logic                           accept;
	logic [LEN_W-1:0]               len;
	logic [PTR_W-1:0]               old_addr;
	logic [LEN_W-1:0]               fill_eff;
	logic [LEN_W-1:0]               fill_new;
	logic signed [SUM_W-1:0]        sum_base;
	logic signed [SUM_W-1:0]        sum_new;
	logic                           drop;

	always_comb begin
		len      = eff_len(len_q);
		full     = (state_q != F_IDLE) || q_stat.full;
		accept   = push && !full;
		old_addr = wp_q - len[PTR_W-1:0];
		fill_eff = item_s1.new_series ? '0 : fill_q;
		sum_base = item_s1.new_series ? '0 : sum_q;
		drop     = (fill_eff >= len);
		sum_new  = sum_base + SUM_W'($signed(item_s1.sample))
			- (drop ? SUM_W'($signed(old_s1)) : SUM_W'(0));
		fill_new = (fill_eff < len) ? fill_eff + LEN_W'(1) : fill_eff;
		q_push   = (state_q == F_UPDATE) && (fill_new >= len);
		q_entry.sum  = sum_new;
		q_entry.len  = len;
		q_entry.mode = mode_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			len_q   <= LEN_W'(1);
			mode_q  <= MODE_SUM;
			sum_q   <= '0;
			fill_q  <= '0;
			wp_q    <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_UPDATE;
					end
				end
				F_UPDATE: begin
					wp_q    <= wp_q + PTR_W'(1);
					state_q <= F_IDLE;
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
			if (cfg_valid && (cfg_index == REG_WINDOW_LEN)) begin
				len_q  <= cfg_data[LEN_W-1:0];
				fill_q <= '0;
				sum_q  <= '0;
			end else if (state_q == F_UPDATE) begin
				sum_q  <= sum_new;
				fill_q <= fill_new;
			end
			if (cfg_valid && (cfg_index == REG_MODE)) begin
				mode_q <= cfg_data[MODE_W-1:0];
			end
		end
	end

	// Delay line: the leaving sample is read when an item is taken, the new one written in the next cycle, in F_UPDATE.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
			old_s1  <= mem[old_addr];
		end
		if (state_q == F_UPDATE) begin
			mem[wp_q] <= item_s1.sample;
		end
	end

endmodule

`default_nettype wire

@@ design/swsmr_queue.sv @@
// Short queue of window sums between the front and back ends.
// Depends on swsmr_pkg for the entry type and the depth.
`default_nettype none

module swsmr_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  swsmr_pkg::entry_t wr_entry,
	input  logic              pop,
	output swsmr_pkg::entry_t rd_entry,
	output swsmr_pkg::qstat_t stat
);
	import swsmr_pkg::*;

	entry_t               slots_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;
	logic                 do_push;
	logic                 do_pop;

	always_comb begin
		stat.empty = (count_q == '0);
		stat.full  = (count_q == Q_CNT_W'(Q_DEPTH));
		do_push    = push && !stat.full;
		do_pop     = pop && !stat.empty;
		rd_entry   = slots_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + Q_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - Q_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

`default_nettype wire

@@ design/swsmr_back.sv @@
// Back end: turns a window sum into sum, mean or root with a shared bit-serial unit.
// Depends on swsmr_pkg; drains swsmr_queue and holds the result register.
`default_nettype none

module swsmr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  swsmr_pkg::entry_t  q_entry,
	input  swsmr_pkg::qstat_t  q_stat,
	output logic               q_pop,
	output swsmr_pkg::result_t result,
	output logic               empty,
	input  logic               pop
);
	import swsmr_pkg::*;

	typedef enum logic [1:0] {B_IDLE, B_DIV, B_ROOT, B_DONE} bstate_t;

	bstate_t                 state_q;
	logic [ROOT_IN_W-1:0]    x_q;
	logic [REM_W-1:0]        rem_q;
	logic [VALUE_W-1:0]      quo_q;
	logic [STEP_CNT_W-1:0]   cnt_q;
	logic                    neg_q;
	logic [LEN_W-1:0]        len_q;
	result_t                 res_q;
	result_t                 out_q;
	logic                    out_valid_q;

	logic [SUM_W-1:0]        mag;
	logic [REM_W-1:0]        div_sh;
	logic                    div_ge;
	logic [REM_W-1:0]        div_rem;
	logic [VALUE_W-1:0]      div_quo;
	logic [VALUE_W-1:0]      div_val;
	logic [REM_W-1:0]        root_sh;
	logic [REM_W-1:0]        root_trial;
	logic                    root_ge;
	logic [REM_W-1:0]        root_rem;
	logic [VALUE_W-1:0]      root_quo;
	logic                    out_load;

	always_comb begin
		q_pop      = (state_q == B_IDLE) && !q_stat.empty;
		mag        = q_entry.sum[SUM_W-1] ? -q_entry.sum : q_entry.sum;
		// Restoring division, one quotient bit per cycle.
		div_sh     = {rem_q[REM_W-2:0], x_q[ROOT_IN_W-1]};
		div_ge     = (div_sh >= REM_W'(len_q));
		div_rem    = div_ge ? div_sh - REM_W'(len_q) : div_sh;
		div_quo    = {quo_q[VALUE_W-2:0], div_ge};
		div_val    = neg_q ? -div_quo : div_quo;
		// Digit-by-digit square root, two radicand bits per cycle.
		root_sh    = {rem_q[REM_W-3:0], x_q[ROOT_IN_W-1 -: 2]};
		root_trial = {quo_q[REM_W-3:0], 2'b01};
		root_ge    = (root_sh >= root_trial);
		root_rem   = root_ge ? root_sh - root_trial : root_sh;
		root_quo   = {quo_q[VALUE_W-2:0], root_ge};
		out_load   = (state_q == B_DONE) && (!out_valid_q || pop);
		empty      = !out_valid_q;
		result     = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			x_q         <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			cnt_q       <= '0;
			neg_q       <= 1'b0;
			len_q       <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (q_pop) begin
						rem_q <= '0;
						quo_q <= '0;
						neg_q <= q_entry.sum[SUM_W-1];
						len_q <= q_entry.len;
						case (q_entry.mode)
							MODE_MEAN: begin
								x_q     <= {mag[VALUE_W-1:0], FRAC_BITS'(0)};
								cnt_q   <= STEP_CNT_W'(DIV_STEPS - 1);
								state_q <= B_DIV;
							end
							MODE_ROOT: begin
								if (q_entry.sum[SUM_W-1]) begin
									res_q.window_value  <= '0;
									res_q.negative_root <= 1'b1;
									state_q             <= B_DONE;
								end else begin
									x_q     <= {q_entry.sum[VALUE_W-1:0], FRAC_BITS'(0)};
									cnt_q   <= STEP_CNT_W'(ROOT_STEPS - 1);
									state_q <= B_ROOT;
								end
							end
							default: begin
								res_q.window_value  <= q_entry.sum[VALUE_W-1:0];
								res_q.negative_root <= 1'b0;
								state_q             <= B_DONE;
							end
						endcase
					end
				end
				B_DIV: begin
					x_q   <= {x_q[ROOT_IN_W-2:0], 1'b0};
					rem_q <= div_rem;
					quo_q <= div_quo;
					cnt_q <= cnt_q - STEP_CNT_W'(1);
					if (cnt_q == '0) begin
						res_q.window_value  <= div_val;
						res_q.negative_root <= 1'b0;
						state_q             <= B_DONE;
					end
				end
				B_ROOT: begin
					x_q   <= {x_q[ROOT_IN_W-3:0], 2'b00};
					rem_q <= root_rem;
					quo_q <= root_quo;
					cnt_q <= cnt_q - STEP_CNT_W'(1);
					if (cnt_q == '0) begin
						res_q.window_value  <= root_quo;
						res_q.negative_root <= 1'b0;
						state_q             <= B_DONE;
					end
				end
				B_DONE: begin
					if (out_load) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
			if (out_load) begin
				out_q       <= res_q;
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ design/sliding_window_sum_mean_root_top.sv @@
// Top level of the sliding window sum, mean and root block.
// Depends on swsmr_pkg, swsmr_front, swsmr_queue, swsmr_back and the macro header.
//
// Usage. Samples enter through a queue-like port: a beat is taken on a rising
// edge with push high and full low. Results leave the same way: while empty is
// low the oldest result sits on result, and a beat is taken when pop is high.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// window_len (index 0) or mode (index 1); cfg_ready is always high. Writing
// window_len restarts the window fill, just as a sample marked new_series does.
// The user must write configuration only while the block holds no unfinished work; the block does not enforce this.
// The front end takes no new sample while it writes the delay line memory
// and the running sum for the last one. Sum mode results pass the input
// register, the queue slot, res_q and out_q; mean mode adds the division
// steps of the shared bit-serial unit and root mode its root steps, which
// also set the sustained rate: the back end takes a sum only when idle.
// Reset clears the running sum, fill count, pointers and queue, sets
// window_len to 1 and mode to sum; the delay line is not cleared. When the
// receiver stalls, the result register holds, the back end waits, the two-entry
// queue fills and full then rises to hold off further samples.
`default_nettype none
`include "sliding_window_sum_mean_root_top_macros.svh"

module sliding_window_sum_mean_root_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  swsmr_pkg::item_t                 item,
	output logic                             empty,
	input  logic                             pop,
	output swsmr_pkg::result_t               result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [swsmr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [swsmr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import swsmr_pkg::*;

	logic   q_push;
	logic   q_pop;
	entry_t q_wr;
	entry_t q_rd;
	qstat_t q_stat;

	// Register writes are plain register updates, so the channel never stalls.
	assign cfg_ready = 1'b1;

	// The front end keeps the delay line and the running sum, and pushes one
	// window sum per sample once the window has filled.
	swsmr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_push    (q_push),
		.q_entry   (q_wr),
		.q_stat    (q_stat)
	);

	// The queue lets the front end carry on while the back end iterates.
	swsmr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr),
		.pop      (q_pop),
		.rd_entry (q_rd),
		.stat     (q_stat)
	);

	// The back end finishes each sum as sum, mean or root and holds it for the receiver.
	swsmr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_entry (q_rd),
		.q_stat  (q_stat),
		.q_pop   (q_pop),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

	// The front end only takes a sample when the queue can absorb its sum.
	`SWSMR_ASSERT_IMP(a_no_push_when_full, q_push, !q_stat.full)
	// The back end only drains the queue when it holds an entry.
	`SWSMR_ASSERT_IMP(a_no_pop_when_empty, q_pop, !q_stat.empty)
	// A sample is worked in the update state after its beat, so the input closes right after a beat.
	`SWSMR_ASSERT_NXT(a_busy_after_beat, push && !full, full)

endmodule

`default_nettype wire
